/* rtl/ffpa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffpa_pkg: shared types and codes of the first-fit page allocator
// Holds the controller states, the command and status bundles between the
// controller and the datapath, and the request and response codes.
// ----------------------------------------------------------------------------
package ffpa_pkg;

  localparam int ADDR_W       = 32;
  localparam int STATUS_W     = 2;
  localparam int PAGES_USED_W = 9;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNKNOWN  = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RECORD,
    ST_MARK,
    ST_RESP
  } ffpa_state_t;

  typedef struct packed {
    logic clr_wr;
    logic take_req;
    logic scan_run;
    logic rec_wr;
    logic mark_wr;
    logic resp_load;
  } ffpa_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic req_ok;
    logic scan_end;
    logic scan_hit;
    logic mark_last;
  } ffpa_stat_t;

endpackage
`default_nettype wire

/* rtl/ffpa_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffpa_ifs: channel interfaces of the first-fit page allocator
// Request, response and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface ffpa_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] alloc_size;
  logic [31:0] free_addr;

  modport source(output valid, output req_type, output alloc_size, output free_addr,
                 input ready);
  modport sink(input valid, input req_type, input alloc_size, input free_addr,
               output ready);
endinterface

interface ffpa_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] block_addr;
  logic [8:0]  pages_used;

  modport source(output valid, output status, output block_addr, output pages_used,
                 input ready);
  modport sink(input valid, input status, input block_addr, input pages_used,
               output ready);
endinterface

interface ffpa_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/ffpa_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffpa_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/ffpa_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffpa_ctrl: controller of the first-fit page allocator
// Sequences the clearing pass, the scan, the record and page updates and the
// loading of the response register.
// ----------------------------------------------------------------------------
module ffpa_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ffpa_pkg::ffpa_cmd_t     cmd,
  input  wire ffpa_pkg::ffpa_stat_t stat
);

  ffpa_pkg::ffpa_state_t state;
  ffpa_pkg::ffpa_state_t state_next;
  logic                  out_valid_next;
  logic                  out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffpa_pkg::ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ffpa_pkg::ST_CLEAR: begin
        if (stat.clr_last) begin
          state_next = ffpa_pkg::ST_IDLE;
        end
      end
      ffpa_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = ffpa_pkg::ST_SCAN;
        end
      end
      ffpa_pkg::ST_SCAN: begin
        priority if (!stat.req_ok) begin
          state_next = ffpa_pkg::ST_RESP;
        end else if (stat.scan_end) begin
          state_next = stat.scan_hit ? ffpa_pkg::ST_RECORD : ffpa_pkg::ST_RESP;
        end else begin
          state_next = ffpa_pkg::ST_SCAN;
        end
      end
      ffpa_pkg::ST_RECORD: begin
        state_next = ffpa_pkg::ST_MARK;
      end
      ffpa_pkg::ST_MARK: begin
        if (stat.mark_last) begin
          state_next = ffpa_pkg::ST_RESP;
        end
      end
      ffpa_pkg::ST_RESP: begin
        if (out_free) begin
          state_next = ffpa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ffpa_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd            = '0;
    in_ready       = 1'b0;
    unique case (state)
      ffpa_pkg::ST_CLEAR:  cmd.clr_wr = 1'b1;
      ffpa_pkg::ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.take_req = in_valid;
      end
      ffpa_pkg::ST_SCAN:   cmd.scan_run = stat.req_ok && !stat.scan_end;
      ffpa_pkg::ST_RECORD: cmd.rec_wr = 1'b1;
      ffpa_pkg::ST_MARK:   cmd.mark_wr = 1'b1;
      ffpa_pkg::ST_RESP:   cmd.resp_load = out_free;
      default: begin
        cmd = '0;
      end
    endcase
    out_valid_next = cmd.resp_load ? 1'b1 : (out_ready ? 1'b0 : out_valid);
  end

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.resp_load |-> (!out_valid || out_ready))
    else $error("response register overwritten while a result is pending");

  a_resp_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.resp_load |=> out_valid)
    else $error("loaded response not presented");

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.take_req |-> in_ready)
    else $error("request taken outside the idle state");
`endif

endmodule
`default_nettype wire

/* rtl/ffpa_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffpa_datapath: datapath of the first-fit page allocator
// Holds the page bitmap and record RAMs, the request registers, the scan and
// mark counters, the used page count and the response register.
// ----------------------------------------------------------------------------
module ffpa_datapath #(
  parameter int PAGE_COUNT = 256,
  parameter int PAGE_SHIFT = 12
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ffpa_pkg::ffpa_cmd_t  cmd,
  output ffpa_pkg::ffpa_stat_t      stat,
  input  wire logic                 cfg_wr,
  input  wire logic [31:0]          cfg_data,
  input  wire logic                 req_type,
  input  wire logic [31:0]          alloc_size,
  input  wire logic [31:0]          free_addr,
  output logic [1:0]                status,
  output logic [31:0]               block_addr,
  output logic [8:0]                pages_used
);

  localparam int PW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int CW = $clog2(PAGE_COUNT + 1);
  localparam int RW = PW + CW;
  localparam int UW = (CW > ffpa_pkg::PAGES_USED_W) ? CW : ffpa_pkg::PAGES_USED_W;
  localparam logic [32:0] PAGE_MASK = 33'((64'd1 << PAGE_SHIFT) - 64'd1);

  logic [31:0]   heap_base;
  logic          r_type;
  logic          r_ok;
  logic [CW-1:0] r_pages;
  logic [PW-1:0] r_page;
  logic [PW-1:0] slot;
  logic          found_run;
  logic          found_slot;
  logic          found_rec;
  logic [CW-1:0] run;
  logic [CW-1:0] idx;
  logic [PW-1:0] idx_q;
  logic          rd_vld;
  logic [PW-1:0] clr_idx;
  logic [PW-1:0] mark_idx;
  logic [CW-1:0] mark_cnt;
  logic [CW-1:0] used;

  logic [32:0]   pages_calc;
  logic [31:0]   offset;
  logic [31:0]   page_calc;
  logic          alloc_ok;
  logic          free_ok;
  logic [CW-1:0] run_inc;
  logic [CW-1:0] start_calc;
  logic          hit;
  logic [UW-1:0] used_ext;

  logic          map_we;
  logic [PW-1:0] map_waddr;
  logic          map_wdata;
  logic          map_rd;
  logic          rec_we;
  logic [PW-1:0] rec_waddr;
  logic [RW-1:0] rec_wdata;
  logic [RW-1:0] rec_rd;
  logic [CW-1:0] rec_rd_pages;
  logic [PW-1:0] rec_rd_start;

  assign pages_calc = ({1'b0, alloc_size} + PAGE_MASK) >> PAGE_SHIFT;
  assign alloc_ok   = (pages_calc != '0) && (pages_calc <= 33'(PAGE_COUNT));
  assign offset     = free_addr - heap_base;
  assign page_calc  = offset >> PAGE_SHIFT;
  assign free_ok    = (free_addr >= heap_base) && (page_calc < 32'(PAGE_COUNT));

  assign rec_rd_pages = rec_rd[CW-1:0];
  assign rec_rd_start = rec_rd[RW-1:CW];
  assign run_inc      = run + CW'(1);
  assign start_calc   = CW'(idx_q) + CW'(1) - r_pages;
  assign hit          = (r_type == ffpa_pkg::REQ_FREE) ? found_rec : (found_run && found_slot);
  assign used_ext     = UW'(used);

  assign stat.clr_last  = clr_idx == PW'(PAGE_COUNT - 1);
  assign stat.req_ok    = r_ok;
  assign stat.scan_hit  = hit;
  assign stat.scan_end  = hit || ((idx == CW'(PAGE_COUNT)) && !rd_vld);
  assign stat.mark_last = (mark_cnt == CW'(1)) || (mark_idx == PW'(PAGE_COUNT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= '0;
    end else if (cfg_wr) begin
      heap_base <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clr_wr) begin
      clr_idx <= clr_idx + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_req) begin
      r_type <= req_type;
      if (req_type == ffpa_pkg::REQ_FREE) begin
        r_ok    <= free_ok;
        r_pages <= '0;
        r_page  <= page_calc[PW-1:0];
      end else begin
        r_ok    <= alloc_ok;
        r_pages <= pages_calc[CW-1:0];
        r_page  <= '0;
      end
    end else if (cmd.scan_run && rd_vld) begin
      if (r_type == ffpa_pkg::REQ_FREE) begin
        if (!found_rec && (rec_rd_pages != '0) && (rec_rd_start == r_page)) begin
          slot    <= idx_q;
          r_pages <= rec_rd_pages;
        end
      end else begin
        if (!found_run && !map_rd && (run_inc == r_pages)) begin
          r_page <= start_calc[PW-1:0];
        end
        if (!found_slot && (rec_rd_pages == '0)) begin
          slot <= idx_q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found_run  <= 1'b0;
      found_slot <= 1'b0;
      found_rec  <= 1'b0;
      run        <= '0;
      idx        <= '0;
      rd_vld     <= 1'b0;
    end else if (cmd.take_req) begin
      found_run  <= 1'b0;
      found_slot <= 1'b0;
      found_rec  <= 1'b0;
      run        <= '0;
      idx        <= '0;
      rd_vld     <= 1'b0;
    end else if (cmd.scan_run) begin
      rd_vld <= idx != CW'(PAGE_COUNT);
      if (idx != CW'(PAGE_COUNT)) begin
        idx <= idx + CW'(1);
      end
      if (rd_vld) begin
        if (r_type == ffpa_pkg::REQ_FREE) begin
          if (!found_rec && (rec_rd_pages != '0) && (rec_rd_start == r_page)) begin
            found_rec <= 1'b1;
          end
        end else begin
          if (!found_run) begin
            if (map_rd) begin
              run <= '0;
            end else begin
              run <= run_inc;
              if (run_inc == r_pages) begin
                found_run <= 1'b1;
              end
            end
          end
          if (!found_slot && (rec_rd_pages == '0)) begin
            found_slot <= 1'b1;
          end
        end
      end
    end else begin
      rd_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    idx_q <= idx[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= '0;
      mark_idx <= '0;
      mark_cnt <= '0;
    end else if (cmd.rec_wr) begin
      mark_idx <= r_page;
      mark_cnt <= r_pages;
      if (r_type == ffpa_pkg::REQ_FREE) begin
        used <= (used >= r_pages) ? (used - r_pages) : '0;
      end else begin
        used <= used + r_pages;
      end
    end else if (cmd.mark_wr) begin
      mark_idx <= mark_idx + PW'(1);
      mark_cnt <= mark_cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp_load) begin
      pages_used <= used_ext[ffpa_pkg::PAGES_USED_W-1:0];
      if (hit) begin
        status     <= ffpa_pkg::STATUS_DONE;
      end else if (r_type == ffpa_pkg::REQ_FREE) begin
        status     <= ffpa_pkg::STATUS_UNKNOWN;
      end else begin
        status     <= ffpa_pkg::STATUS_NO_SPACE;
      end
      if (hit && (r_type == ffpa_pkg::REQ_ALLOC)) begin
        block_addr <= heap_base + (32'(r_page) << PAGE_SHIFT);
      end else begin
        block_addr <= '0;
      end
    end
  end

  assign map_we    = cmd.clr_wr || cmd.mark_wr;
  assign map_waddr = cmd.clr_wr ? clr_idx : mark_idx;
  assign map_wdata = !cmd.clr_wr && (r_type == ffpa_pkg::REQ_ALLOC);

  assign rec_we    = cmd.clr_wr || cmd.rec_wr;
  assign rec_waddr = cmd.clr_wr ? clr_idx : slot;
  assign rec_wdata = (cmd.clr_wr || (r_type == ffpa_pkg::REQ_FREE)) ? '0 : {r_page, r_pages};

  ffpa_ram #(
    .WIDTH (1),
    .DEPTH (PAGE_COUNT)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (idx[PW-1:0]),
    .rdata (map_rd)
  );

  ffpa_ram #(
    .WIDTH (RW),
    .DEPTH (PAGE_COUNT)
  ) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .raddr (idx[PW-1:0]),
    .rdata (rec_rd)
  );

`ifndef NO_ASSERTIONS
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CW'(PAGE_COUNT))
    else $error("used page count exceeds the heap size");

  a_mark_count: assert property (@(posedge clk) disable iff (rst)
    cmd.mark_wr |-> (mark_cnt != '0))
    else $error("page mark issued with no pages left");

  a_run_fits: assert property (@(posedge clk) disable iff (rst)
    (cmd.rec_wr && (r_type == ffpa_pkg::REQ_ALLOC)) |->
      ((CW + 1)'(r_page) + (CW + 1)'(r_pages) <= (CW + 1)'(PAGE_COUNT)))
    else $error("allocated run extends past the last page");
`endif

endmodule
`default_nettype wire

/* rtl/first_fit_page_allocator_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_page_allocator_unit: first-fit bitmap page heap allocator
// Allocates runs of pages from a bitmap and frees them by start address.
// ----------------------------------------------------------------------------
// After reset the unit clears its page bitmap and record RAMs in a pass over
// all PAGE_COUNT entries, during which no request is accepted; configuration
// writes are taken at any time. One request is handled at a time. A request
// is accepted in the idle state and then scanned; on success a record step
// follows, then a pass that marks or clears each page of the block, and
// last the response is loaded, while a failed request goes from the scan
// straight to loading the response. The scan reads one bitmap entry and one
// record slot per cycle through the single read port of each RAM, and the
// marking pass writes one bitmap entry per cycle. The next request is
// accepted while the previous response still waits in the output register.
module first_fit_page_allocator_unit #(
  parameter int PAGE_COUNT = 256,
  parameter int PAGE_SHIFT = 12
) (
  input wire logic  clk,
  input wire logic  rst,
  ffpa_req_if.sink  req,
  ffpa_rsp_if.source rsp,
  ffpa_cfg_if.sink  cfg
);

  ffpa_pkg::ffpa_cmd_t  cmd;
  ffpa_pkg::ffpa_stat_t stat;

  assign cfg.ready = 1'b1;

  ffpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  ffpa_datapath #(
    .PAGE_COUNT (PAGE_COUNT),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_wr     (cfg.valid),
    .cfg_data   (cfg.data),
    .req_type   (req.req_type),
    .alloc_size (req.alloc_size),
    .free_addr  (req.free_addr),
    .status     (rsp.status),
    .block_addr (rsp.block_addr),
    .pages_used (rsp.pages_used)
  );

endmodule
`default_nettype wire

/* dv/first_fit_page_allocator_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_page_allocator_unit_tb: self-checking bench of the page allocator
// A queue of allocate and free requests feeds a clocked driver, and a
// clocked monitor takes the responses. The bench keeps its own copy of the
// page bitmap, the allocation records and the used page count, and predicts
// every response when its request is accepted. Each response is checked
// field by field. The heap base is rewritten between phases while the unit
// is idle. Both channels see random gaps and stalls.
// ----------------------------------------------------------------------------
module first_fit_page_allocator_unit_tb;

  localparam int PAGE_COUNT     = 256;
  localparam int PAGE_SHIFT     = 12;
  localparam int PAGE_BYTES     = 1 << PAGE_SHIFT;
  localparam int DIRECTED_COUNT = 24;
  localparam int RANDOM_PHASES  = 5;
  localparam int PHASE_REQUESTS = 180;
  localparam int TOTAL_REQUESTS = DIRECTED_COUNT + RANDOM_PHASES * PHASE_REQUESTS;
  localparam int CYCLE_LIMIT    = TOTAL_REQUESTS * (2 * PAGE_COUNT + 1216) * 4
                                  + 4 * PAGE_COUNT;

  typedef enum int {
    AIM_RAW,
    AIM_LIVE,
    AIM_LIVE_OFS,
    AIM_INNER,
    AIM_BELOW,
    AIM_PAST,
    AIM_PAGE
  } free_aim_t;

  typedef struct {
    logic                        req_type;
    logic [ffpa_pkg::ADDR_W-1:0] alloc_size;
    logic [ffpa_pkg::ADDR_W-1:0] free_addr;
    free_aim_t                   aim;
  } heap_request_t;

  typedef struct {
    logic [ffpa_pkg::STATUS_W-1:0]     status;
    logic [ffpa_pkg::ADDR_W-1:0]       block_addr;
    logic [ffpa_pkg::PAGES_USED_W-1:0] pages_used;
  } heap_answer_t;

  logic clk;
  logic rst;

  ffpa_req_if req_ch();
  ffpa_rsp_if rsp_ch();
  ffpa_cfg_if cfg_ch();

  first_fit_page_allocator_unit #(
    .PAGE_COUNT(PAGE_COUNT),
    .PAGE_SHIFT(PAGE_SHIFT)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  bit                                page_busy[PAGE_COUNT];
  logic [7:0]                        rec_start[PAGE_COUNT];
  logic [8:0]                        rec_pages[PAGE_COUNT];
  logic [ffpa_pkg::PAGES_USED_W-1:0] pages_in_use;
  logic [ffpa_pkg::ADDR_W-1:0]       heap_base_q;

  heap_request_t pending_requests[$];
  heap_answer_t  expected_answers[$];
  heap_request_t active_request;

  int unsigned mismatch_count;
  int unsigned answers_seen;
  int unsigned cycle_count;
  int          drv_gap;
  int          rcv_hold;
  bit          drv_calm;
  bit          rcv_calm;
  bit          drive_next;
  bit          answer_taken;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int stall_len(input bit calm);
    int r;
    r = $urandom_range(0, 199);
    if (calm || r < 110) return 0;
    if (r < 170) return $urandom_range(1, 3);
    if (r < 194) return $urandom_range(4, 16);
    if (r < 199) return $urandom_range(20, 60);
    return $urandom_range(300, 600);
  endfunction

  // Applies one request to the local heap copy and returns its response.
  function automatic heap_answer_t page_heap_answer(input heap_request_t rq);
    heap_answer_t ans;
    logic [32:0]  npages;
    logic [31:0]  page;
    int           want_pages;
    int           run;
    int           first;
    int           slot;
    int           p;
    int           s;
    ans.status     = ffpa_pkg::STATUS_DONE;
    ans.block_addr = '0;
    if (rq.req_type == ffpa_pkg::REQ_ALLOC) begin
      npages = ({1'b0, rq.alloc_size} + 33'(PAGE_BYTES - 1)) >> PAGE_SHIFT;
      want_pages = (npages == 0 || npages > PAGE_COUNT) ? 0 : int'(npages);
      first = -1;
      slot  = -1;
      if (want_pages != 0) begin
        run = 0;
        for (p = 0; p < PAGE_COUNT; p++) begin
          if (page_busy[p]) begin
            run = 0;
          end else begin
            run++;
            if (run == want_pages) begin
              first = p + 1 - want_pages;
              break;
            end
          end
        end
      end
      if (first >= 0) begin
        for (s = 0; s < PAGE_COUNT; s++) begin
          if (rec_pages[s] == 0) begin
            slot = s;
            break;
          end
        end
      end
      if (first < 0 || slot < 0) begin
        ans.status = ffpa_pkg::STATUS_NO_SPACE;
      end else begin
        rec_start[slot] = first[7:0];
        rec_pages[slot] = want_pages[8:0];
        for (p = first; p < first + want_pages; p++) page_busy[p] = 1'b1;
        pages_in_use   = pages_in_use + want_pages[8:0];
        ans.block_addr = heap_base_q + (32'(first) << PAGE_SHIFT);
      end
    end else begin
      ans.status = ffpa_pkg::STATUS_UNKNOWN;
      if (rq.free_addr >= heap_base_q) begin
        page = (rq.free_addr - heap_base_q) >> PAGE_SHIFT;
        if (page < PAGE_COUNT) begin
          for (s = 0; s < PAGE_COUNT; s++) begin
            if (rec_pages[s] != 0 && rec_start[s] == page) begin
              for (p = int'(page); p < int'(page) + rec_pages[s] && p < PAGE_COUNT; p++)
                page_busy[p] = 1'b0;
              pages_in_use = (pages_in_use >= rec_pages[s]) ? pages_in_use - rec_pages[s]
                                                              : '0;
              rec_pages[s] = '0;
              rec_start[s] = '0;
              ans.status   = ffpa_pkg::STATUS_DONE;
              break;
            end
          end
        end
      end
    end
    ans.pages_used = pages_in_use;
    return ans;
  endfunction

  // Frees that name a live block get their address from the current heap copy.
  function automatic heap_request_t aim_request(input heap_request_t rq);
    int          live[$];
    int          s;
    int          pick;
    logic [31:0] start_addr;
    for (s = 0; s < PAGE_COUNT; s++) begin
      if (rec_pages[s] != 0) live.push_back(s);
    end
    case (rq.aim)
      AIM_LIVE, AIM_LIVE_OFS, AIM_INNER: begin
        if (live.size() == 0) begin
          rq.free_addr = heap_base_q + ($urandom_range(0, PAGE_COUNT - 1) << PAGE_SHIFT);
        end else begin
          pick = live[$urandom_range(0, live.size() - 1)];
          start_addr = heap_base_q + (32'(rec_start[pick]) << PAGE_SHIFT);
          if (rq.aim == AIM_LIVE) begin
            rq.free_addr = start_addr;
          end else if (rq.aim == AIM_LIVE_OFS) begin
            rq.free_addr = start_addr + $urandom_range(0, PAGE_BYTES - 1);
          end else begin
            rq.free_addr = start_addr + ($urandom_range(0, rec_pages[pick] - 1) << PAGE_SHIFT)
                           + $urandom_range(0, PAGE_BYTES - 1);
          end
        end
      end
      AIM_BELOW: begin
        rq.free_addr = (heap_base_q == 0) ? $urandom() : $urandom_range(0, heap_base_q - 1);
      end
      AIM_PAST: begin
        rq.free_addr = heap_base_q + (PAGE_COUNT << PAGE_SHIFT) + $urandom_range(0, 32'hFFFF);
      end
      AIM_PAGE: begin
        rq.free_addr = heap_base_q + ($urandom_range(0, PAGE_COUNT - 1) << PAGE_SHIFT);
      end
      default: begin
      end
    endcase
    return rq;
  endfunction

  function automatic heap_request_t alloc_request(input logic [31:0] size);
    heap_request_t rq;
    rq.req_type   = ffpa_pkg::REQ_ALLOC;
    rq.alloc_size = size;
    rq.free_addr  = $urandom();
    rq.aim        = AIM_RAW;
    return rq;
  endfunction

  function automatic heap_request_t free_request(input free_aim_t aim, input logic [31:0] addr);
    heap_request_t rq;
    rq.req_type   = ffpa_pkg::REQ_FREE;
    rq.alloc_size = $urandom();
    rq.free_addr  = addr;
    rq.aim        = aim;
    return rq;
  endfunction

  function automatic heap_request_t random_request();
    int          r;
    int          k;
    logic [31:0] size;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      k = $urandom_range(0, 99);
      if (k < 70) size = $urandom_range(1, 8 * PAGE_BYTES);
      else if (k < 85) size = $urandom_range(1, 16) << PAGE_SHIFT;
      else if (k < 93) size = ($urandom_range(32, PAGE_COUNT) << PAGE_SHIFT)
                              - $urandom_range(0, PAGE_BYTES - 1);
      else if (k < 96) size = '0;
      else size = $urandom();
      return alloc_request(size);
    end
    if (r < 72) return free_request(AIM_LIVE, '0);
    if (r < 85) return free_request(AIM_LIVE_OFS, '0);
    case ($urandom_range(0, 4))
      0: return free_request(AIM_BELOW, '0);
      1: return free_request(AIM_PAST, '0);
      2: return free_request(AIM_PAGE, '0);
      3: return free_request(AIM_INNER, '0);
      default: return free_request(AIM_RAW, $urandom());
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("mismatch in %s at response %0d: got 0x%0h, expected 0x%0h",
             what, answers_seen, got, want);
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_requests.size() != 0 || req_ch.valid || expected_answers.size() != 0);
  endtask

  task automatic write_heap_base(input logic [31:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk);
    while (!cfg_ch.ready);
    heap_base_q = value;
    cfg_ch.valid <= 1'b0;
  endtask

  // Request driver: predicts each accepted transaction and presents the next one.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      drive_next = req_ch.valid;
      if (req_ch.valid && req_ch.ready) begin
        expected_answers.push_back(page_heap_answer(active_request));
        drive_next = 1'b0;
        if ($urandom_range(0, 39) == 0) drv_calm = !drv_calm;
        drv_gap = stall_len(drv_calm);
      end
      if (!drive_next) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (pending_requests.size() > 0) begin
          active_request = aim_request(pending_requests.pop_front());
          req_ch.req_type   <= active_request.req_type;
          req_ch.alloc_size <= active_request.alloc_size;
          req_ch.free_addr  <= active_request.free_addr;
          drive_next = 1'b1;
        end
      end
      req_ch.valid <= drive_next;
    end
  end

  // Response monitor with random backpressure.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      answer_taken = rsp_ch.valid && rsp_ch.ready;
      if (answer_taken) begin
        answers_seen++;
        if (expected_answers.size() == 0) begin
          report_mismatch("unexpected response status", 32'(rsp_ch.status), '0);
        end else begin
          heap_answer_t want;
          want = expected_answers.pop_front();
          if (rsp_ch.status !== want.status)
            report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
          if (rsp_ch.block_addr !== want.block_addr)
            report_mismatch("block_addr", rsp_ch.block_addr, want.block_addr);
          if (rsp_ch.pages_used !== want.pages_used)
            report_mismatch("pages_used", 32'(rsp_ch.pages_used), 32'(want.pages_used));
        end
      end
      if (rcv_hold == 0 && (answer_taken || $urandom_range(0, 31) == 0)) begin
        if ($urandom_range(0, 39) == 0) rcv_calm = !rcv_calm;
        rcv_hold = stall_len(rcv_calm);
      end
      if (rcv_hold > 0) begin
        rcv_hold--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [31:0] heap_bases[RANDOM_PHASES];
    int          ph;
    int          i;
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = ffpa_pkg::REQ_ALLOC;
    req_ch.alloc_size = '0;
    req_ch.free_addr  = '0;
    rsp_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.data       = '0;
    heap_base_q       = '0;
    pages_in_use      = '0;
    for (i = 0; i < PAGE_COUNT; i++) begin
      page_busy[i] = 1'b0;
      rec_start[i] = '0;
      rec_pages[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    write_heap_base(32'h0010_0000);
    @(negedge clk);
    pending_requests.push_back(alloc_request(32'd0));
    pending_requests.push_back(alloc_request(32'd1));
    pending_requests.push_back(alloc_request(PAGE_BYTES));
    pending_requests.push_back(alloc_request(PAGE_BYTES + 1));
    pending_requests.push_back(alloc_request(32'hFFFF_FFFF));
    pending_requests.push_back(alloc_request((PAGE_COUNT + 1) << PAGE_SHIFT));
    pending_requests.push_back(alloc_request(PAGE_COUNT << PAGE_SHIFT));
    pending_requests.push_back(free_request(AIM_BELOW, '0));
    pending_requests.push_back(free_request(AIM_PAST, '0));
    pending_requests.push_back(free_request(AIM_RAW, 32'hFFFF_FFFF));
    pending_requests.push_back(free_request(AIM_INNER, '0));
    pending_requests.push_back(free_request(AIM_LIVE_OFS, '0));
    pending_requests.push_back(free_request(AIM_PAGE, '0));
    pending_requests.push_back(free_request(AIM_LIVE, '0));
    pending_requests.push_back(free_request(AIM_LIVE, '0));
    pending_requests.push_back(free_request(AIM_LIVE, '0));
    pending_requests.push_back(alloc_request(PAGE_COUNT << PAGE_SHIFT));
    pending_requests.push_back(alloc_request(32'd1));
    pending_requests.push_back(free_request(AIM_LIVE, '0));
    pending_requests.push_back(alloc_request((PAGE_COUNT - 1) << PAGE_SHIFT));
    pending_requests.push_back(alloc_request(PAGE_BYTES));
    pending_requests.push_back(alloc_request(32'd1));
    pending_requests.push_back(free_request(AIM_LIVE, '0));
    pending_requests.push_back(free_request(AIM_LIVE, '0));

    heap_bases[0] = 32'h0000_0000;
    heap_bases[1] = 32'hFFF0_0000;
    heap_bases[2] = $urandom_range(0, 32'hFFF00) << PAGE_SHIFT;
    heap_bases[3] = $urandom_range(0, 32'hFFF0_0000);
    heap_bases[4] = $urandom_range(0, 32'hFFF00) << PAGE_SHIFT;
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_quiet();
      write_heap_base(heap_bases[ph]);
      @(negedge clk);
      for (i = 0; i < PHASE_REQUESTS; i++) pending_requests.push_back(random_request());
    end

    wait_quiet();
    repeat (2 * PAGE_COUNT + 16) @(posedge clk);
    if (mismatch_count == 0 && expected_answers.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
